/* hw/rtl/pol_pkg.sv */
// package: sizes, operation codes, controller states and cell control for the positional list
`timescale 1ns / 1ps
package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int CODE_W   = 32;
  localparam int POS_W    = 8;
  localparam int OP_W     = 2;
  localparam int LEN_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int GRP_SZ   = 8;
  localparam int GRP_N    = (CAPACITY + GRP_SZ - 1) / GRP_SZ;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_RETRIEVE = 2'd0,
    OP_INSERT   = 2'd1,
    OP_REMOVE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_REDUCE
  } state_e;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
  } cell_ctrl_t;

endpackage

/* hw/rtl/positional_ordered_list.sv */
// top level: positional list as a row of shifting cells with a registered read tree
//
//  channel  | dir | tdata (low bit up)                  | tuser
//  s_axis   | in  | position[7:0], entry_code[39:8]     | op[1:0]
//  m_axis   | out | read_code[31:0], length[38:32]      | ok[0]
//
//  insert, remove and any failing item load their result when accepted; a
//  successful retrieve goes through accept, cell select and group or, final or
//  one item at a time; an item is taken when the output register is empty
//  or its result leaves in the same cycle, never while a retrieve is pending
//  reset empties the list at once; entry contents are not cleared
`timescale 1ns / 1ps
module positional_ordered_list (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [pol_pkg::IN_DW-1:0]  s_axis_tdata_i,  // position, entry_code
  input  logic [pol_pkg::OP_W-1:0]   s_axis_tuser_i,  // op
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [pol_pkg::OUT_DW-1:0] m_axis_tdata_o,  // read_code, length, zero pad
  output logic [0:0]                 m_axis_tuser_o   // ok
);

  pol_pkg::state_e state_q, state_d;

  logic [pol_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pol_pkg::IDX_W-1:0]  idx_q;
  logic                       m_valid_q;
  logic                       ok_q;
  logic [pol_pkg::CODE_W-1:0] rd_q;
  logic [pol_pkg::LEN_W-1:0]  len_q;
  logic [pol_pkg::CODE_W-1:0] grp_q [pol_pkg::GRP_N];
  logic [pol_pkg::CODE_W-1:0] grp_d [pol_pkg::GRP_N];
  logic [pol_pkg::CODE_W-1:0] rd_tree;

  logic [pol_pkg::OP_W-1:0]   op;
  logic [pol_pkg::POS_W-1:0]  pos;
  logic [pol_pkg::CODE_W-1:0] code;
  logic [pol_pkg::POS_W:0]    pos_x;
  logic [pol_pkg::POS_W:0]    cnt_x;
  logic [pol_pkg::IDX_W-1:0]  idx_now;
  logic                       in_range;
  logic                       ins_ok;
  logic                       is_ret, is_ins, is_rem;
  logic                       out_free;
  logic                       accept;
  logic                       ret_go;
  logic                       do_ins, do_rem;
  logic                       load_fast, load_rd;
  logic                       fast_ok;

  pol_pkg::cell_ctrl_t        ctrl;
  logic [pol_pkg::CODE_W-1:0] cell_data [pol_pkg::CAPACITY];
  logic [pol_pkg::CODE_W-1:0] cell_rd   [pol_pkg::CAPACITY];

  assign op   = s_axis_tuser_i;
  assign pos  = s_axis_tdata_i[pol_pkg::POS_W-1:0];
  assign code = s_axis_tdata_i[pol_pkg::POS_W +: pol_pkg::CODE_W];

  assign pos_x    = {1'b0, pos};
  assign cnt_x    = (pol_pkg::POS_W + 1)'(cnt_q);
  assign idx_now  = pol_pkg::IDX_W'(pos_x - 1'b1);
  assign in_range = (pos != '0) && (pos_x <= cnt_x);
  assign ins_ok   = (cnt_q < pol_pkg::CNT_W'(pol_pkg::CAPACITY)) && (pos != '0)
                    && (pos_x <= cnt_x + 1'b1);

  assign is_ret = (op == pol_pkg::OP_RETRIEVE);
  assign is_ins = (op == pol_pkg::OP_INSERT);
  assign is_rem = (op == pol_pkg::OP_REMOVE);

  assign out_free = !m_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pol_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i && out_free && is_ret && in_range) begin
          state_d = pol_pkg::ST_GATHER;
        end
      end
      pol_pkg::ST_GATHER: begin
        state_d = pol_pkg::ST_REDUCE;
      end
      pol_pkg::ST_REDUCE: begin
        if (out_free) begin
          state_d = pol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pol_pkg::ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    load_rd         = 1'b0;
    unique case (state_q)
      pol_pkg::ST_IDLE: begin
        s_axis_tready_o = out_free;
      end
      pol_pkg::ST_GATHER: begin
      end
      pol_pkg::ST_REDUCE: begin
        load_rd = out_free;
      end
      default: begin
      end
    endcase
  end

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign ret_go    = accept && is_ret && in_range;
  assign do_ins    = accept && is_ins && ins_ok;
  assign do_rem    = accept && is_rem && in_range;
  assign load_fast = accept && !ret_go;
  assign fast_ok   = do_ins || do_rem;

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rem) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign ctrl.ins  = do_ins;
  assign ctrl.rem  = do_rem;
  assign ctrl.idx  = (state_q == pol_pkg::ST_IDLE) ? idx_now : idx_q;
  assign ctrl.code = code;

  for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
    logic [pol_pkg::CODE_W-1:0] left_w;
    logic [pol_pkg::CODE_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = code;
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end
    if (i == pol_pkg::CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (pol_pkg::IDX_W'(i)),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // group or of the selected cell output
  always_comb begin
    for (int g = 0; g < pol_pkg::GRP_N; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < pol_pkg::GRP_SZ; k++) begin
        if (g * pol_pkg::GRP_SZ + k < pol_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * pol_pkg::GRP_SZ + k];
        end
      end
    end
  end

  always_comb begin
    rd_tree = '0;
    for (int g = 0; g < pol_pkg::GRP_N; g++) begin
      rd_tree = rd_tree | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pol_pkg::ST_GATHER) begin
      for (int g = 0; g < pol_pkg::GRP_N; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
    if (accept) begin
      idx_q <= idx_now;
    end
    if (load_fast) begin
      ok_q  <= fast_ok;
      rd_q  <= '0;
      len_q <= pol_pkg::LEN_W'(cnt_d);
    end else if (load_rd) begin
      ok_q  <= 1'b1;
      rd_q  <= rd_tree;
      len_q <= pol_pkg::LEN_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pol_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_fast || load_rd) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = ok_q;
  assign m_axis_tdata_o  = {(pol_pkg::OUT_DW - pol_pkg::CODE_W - pol_pkg::LEN_W)'(0),
                            len_q, rd_q};

endmodule

/* hw/rtl/pol_cell.sv */
// one list cell: holds one entry, shifts to or from its neighbors on insert and remove
`timescale 1ns / 1ps
module pol_cell (
  input  logic                       clk_i,
  input  pol_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pol_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic [pol_pkg::CODE_W-1:0] left_i,
  input  logic [pol_pkg::CODE_W-1:0] right_i,
  output logic [pol_pkg::CODE_W-1:0] data_o,
  output logic [pol_pkg::CODE_W-1:0] rd_o
);

  logic [pol_pkg::CODE_W-1:0] data_q;
  logic [pol_pkg::CODE_W-1:0] data_d;

  always_comb begin
    priority if (ctrl_i.ins && (cell_idx_i > ctrl_i.idx)) begin
      data_d = left_i;
    end else if (ctrl_i.ins && (cell_idx_i == ctrl_i.idx)) begin
      data_d = ctrl_i.code;
    end else if (ctrl_i.rem && (cell_idx_i >= ctrl_i.idx)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (cell_idx_i == ctrl_i.idx) ? data_q : '0;

endmodule

/* test/positional_ordered_list_tb.sv */
// testbench: random and directed insert, remove and retrieve traffic against a local list model
`timescale 1ns / 1ps
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT  = 11;
  localparam int HOLD_CYC  = 300;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
  } request_t;

  // pause: sender waits here until every answer is back
  typedef struct packed {
    logic     pause;
    request_t req;
  } slot_t;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] read_code;
    logic [LEN_W-1:0]  length;
  } answer_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_DW-1:0]   s_tdata;
  logic [OP_W-1:0]    s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_DW-1:0]  m_tdata;
  logic [0:0]         m_tuser;

  positional_ordered_list u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // list model
  logic [CODE_W-1:0] list_mem [CAPACITY];
  int                list_len;

  slot_t    request_q [$];
  answer_t  answer_q [$];
  request_t cur_req;
  bit       taken;
  int       sent_n;
  int       recv_n;
  int       err_n;
  int       gen_len;
  int       hold_left;
  bit       hold_done;

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int      p;
    a = '0;
    p = r.pos;
    case (op_e'(r.op))
      OP_RETRIEVE: begin
        if (p >= 1 && p <= list_len) begin
          a.read_code = list_mem[p-1];
          a.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (list_len < CAPACITY && p >= 1 && p <= list_len + 1) begin
          for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = r.code;
          list_len++;
          a.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (p >= 1 && p <= list_len) begin
          for (int i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
          a.ok = 1'b1;
        end
      end
      default: a.ok = 1'b0;
    endcase
    a.length = LEN_W'(list_len);
    return a;
  endfunction

  // queue one item and track the length it leaves behind
  task automatic add(logic [OP_W-1:0] op, int pos, logic [CODE_W-1:0] code);
    slot_t s;
    s.pause    = 1'b0;
    s.req.op   = op;
    s.req.pos  = POS_W'(pos);
    s.req.code = code;
    request_q.push_back(s);
    if (op == OP_INSERT && gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1) begin
      gen_len++;
    end else if (op == OP_REMOVE && pos >= 1 && pos <= gen_len) begin
      gen_len--;
    end
  endtask

  task automatic add_pause();
    slot_t s;
    s = '0;
    s.pause = 1'b1;
    request_q.push_back(s);
  endtask

  task automatic add_random(int mode);
    int               r;
    int               pos;
    logic [OP_W-1:0]  op;
    r = $urandom_range(99);
    // mode 0 fills, 1 drains, 2 mixes
    if (r < 4) begin
      op = OP_UNUSED;
    end else if (mode == 0) begin
      op = (r < 70) ? OP_INSERT : (r < 85) ? OP_REMOVE : OP_RETRIEVE;
    end else if (mode == 1) begin
      op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_INSERT : OP_RETRIEVE;
    end else begin
      op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REMOVE : OP_RETRIEVE;
    end
    if ($urandom_range(99) < 8) begin
      pos = $urandom_range(255);
    end else if (op == OP_INSERT) begin
      pos = $urandom_range(gen_len + 1, 1);
    end else if (gen_len > 0) begin
      pos = $urandom_range(gen_len, 1);
    end else begin
      pos = $urandom_range(1);
    end
    add(op, pos, $urandom);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // accept side: model the item at the handshake
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      answer_q.push_back(apply_request(cur_req));
      sent_n++;
      taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_requests
    logic     nxt_valid;
    request_t nxt;
    slot_t    s;
    if (rst_ni && (taken || !s_tvalid)) begin
      taken = 1'b0;
      nxt_valid = 1'b0;
      nxt = cur_req;
      if (request_q.size() > 0 && request_q[0].pause) begin
        if (answer_q.size() == 0) s = request_q.pop_front();
      end else if (request_q.size() > 0 &&
                   ((sent_n >= 100 && sent_n < 250) || $urandom_range(99) >= IDLE_PCT)) begin
        s = request_q.pop_front();
        nxt = s.req;
        nxt_valid = 1'b1;
      end
      cur_req = nxt;
      s_tvalid <= nxt_valid;
      s_tdata  <= {nxt.code, nxt.pos};
      s_tuser  <= nxt.op;
    end
  end

  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    if (rst_ni) begin
      if (!hold_done && recv_n >= 350) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = (recv_n >= 100 && recv_n < 250) || $urandom_range(99) >= IDLE_PCT;
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin : check_answers
    answer_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      recv_n++;
      if (answer_q.size() == 0) begin
        $error("result item with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
        err_n++;
      end else begin
        want = answer_q.pop_front();
        if (m_tuser[0] !== want.ok) begin
          $error("ok: expected %b actual %b", want.ok, m_tuser[0]);
          err_n++;
        end
        if (m_tdata[CODE_W-1:0] !== want.read_code) begin
          $error("read_code: expected %h actual %h", want.read_code, m_tdata[CODE_W-1:0]);
          err_n++;
        end
        if (m_tdata[CODE_W +: LEN_W] !== want.length) begin
          $error("length: expected %0d actual %0d", want.length, m_tdata[CODE_W +: LEN_W]);
          err_n++;
        end
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cur_req   = '0;
    taken     = 1'b0;
    sent_n    = 0;
    recv_n    = 0;
    err_n     = 0;
    gen_len   = 0;
    list_len  = 0;
    hold_left = 0;
    hold_done = 1'b0;

    // directed: empty list, bounds, extremes of code, every op
    add(OP_RETRIEVE, 1, '0);
    add(OP_REMOVE,   1, '0);
    add(OP_INSERT,   0, 32'h1234_5678);
    add(OP_INSERT,   2, 32'h1234_5678);
    add(OP_INSERT,   1, 32'h8000_0000);
    add(OP_INSERT,   2, 32'h7FFF_FFFF);
    add(OP_INSERT,   1, 32'h0000_0000);
    add(OP_INSERT,   2, 32'hFFFF_FFFF);
    for (int i = 1; i <= 5; i++) add(OP_RETRIEVE, i, 32'hFFFF_FFFF);
    add(OP_RETRIEVE, 255, '0);
    add(OP_INSERT,   255, 32'hA5A5_A5A5);
    add(OP_UNUSED,   1, 32'hFFFF_FFFF);
    add(OP_REMOVE,   2, '0);
    add(OP_REMOVE,   3, '0);
    add(OP_REMOVE,   0, '0);
    add(OP_REMOVE,   4, '0);
    add(OP_RETRIEVE, 1, '0);
    add(OP_RETRIEVE, 2, '0);
    add(OP_RETRIEVE, 0, '0);
    add_pause();

    // random: blocks of fill, drain and mixed traffic
    for (int b = 0; b < 15; b++) begin
      for (int i = 0; i < 40; i++) begin
        add_random((b % 8 < 3) ? 0 : (b % 8 == 3 || b % 8 == 7) ? 2 : 1);
      end
      if (b == 10) add_pause();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (request_q.size() > 0 || s_tvalid || answer_q.size() > 0);
    repeat (20) @(posedge clk_i);

    if (err_n == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pol_pkg.sv
hw/rtl/pol_cell.sv
hw/rtl/positional_ordered_list.sv
test/positional_ordered_list_tb.sv
